### hdl/lhq_pkg.sv
// ----------------------------------------------------------------------------
// lhq_pkg
// Shared types and constants of the line hull maximum query block.
// ----------------------------------------------------------------------------
package lhq_pkg;

    localparam int LHQ_CAPACITY = 64;

    localparam logic signed [63:0] HULL_INF     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] HULL_NEG_INF = 64'sh8000_0000_0000_0001;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic signed [63:0] bp;
    } t_line;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT,
        CELL_SET_BP
    } t_cell_op;

    typedef enum logic [2:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_POP_SECOND,
        STK_SET_BP,
        STK_CLEAR
    } t_stack_op;

    typedef struct packed {
        t_stack_op          op;
        t_line              push;
        logic signed [63:0] bp;
    } t_stack_ctl;

endpackage

### hdl/lhq_cell.sv
// ----------------------------------------------------------------------------
// lhq_cell
// One storage cell of a line stack; takes a line from either neighbor.
// ----------------------------------------------------------------------------
module lhq_cell (
    input  logic               i_clk,
    input  lhq_pkg::t_cell_op  i_op,
    input  lhq_pkg::t_line     i_prev,
    input  lhq_pkg::t_line     i_next,
    input  logic signed [63:0] i_bp,
    output lhq_pkg::t_line     o_line
);
    import lhq_pkg::*;

    t_line r_line;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_TAKE_PREV: r_line <= i_prev;
            CELL_TAKE_NEXT: r_line <= i_next;
            CELL_SET_BP:    r_line.bp <= i_bp;
            default:        r_line <= r_line;
        endcase
    end

    assign o_line = r_line;

endmodule

### hdl/lhq_stack.sv
// ----------------------------------------------------------------------------
// lhq_stack
// A chain of line cells used as a stack; only the two top cells are read.
// ----------------------------------------------------------------------------
module lhq_stack #(
    parameter  int DEPTH = lhq_pkg::LHQ_CAPACITY,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lhq_pkg::t_stack_ctl i_ctl,
    output lhq_pkg::t_line      o_top,
    output lhq_pkg::t_line      o_second,
    output logic [CNT_W-1:0]    o_count
);
    import lhq_pkg::*;

    t_line            w_line [DEPTH];
    t_cell_op         w_op   [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            case (i_ctl.op)
                STK_PUSH:       w_op[i] = CELL_TAKE_PREV;
                STK_POP:        w_op[i] = CELL_TAKE_NEXT;
                STK_POP_SECOND: w_op[i] = (i == 0) ? CELL_SET_BP : CELL_TAKE_NEXT;
                STK_SET_BP:     w_op[i] = (i == 0) ? CELL_SET_BP : CELL_HOLD;
                default:        w_op[i] = CELL_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_line w_prev;
        t_line w_next;
        if (g == 0) begin : g_head
            assign w_prev = i_ctl.push;
        end else begin : g_body
            assign w_prev = w_line[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_line[g];
        end else begin : g_inner
            assign w_next = w_line[g+1];
        end
        lhq_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op[g]),
            .i_prev (w_prev),
            .i_next (w_next),
            .i_bp   (i_ctl.bp),
            .o_line (w_line[g])
        );
    end

    always_comb begin
        case (i_ctl.op)
            STK_PUSH:       n_count = r_count + CNT_W'(1);
            STK_POP:        n_count = r_count - CNT_W'(1);
            STK_POP_SECOND: n_count = r_count - CNT_W'(1);
            STK_CLEAR:      n_count = '0;
            default:        n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top    = w_line[0];
    assign o_second = w_line[1];
    assign o_count  = r_count;

endmodule

### hdl/lhq_div.sv
// ----------------------------------------------------------------------------
// lhq_div
// Floored signed division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lhq_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quot
);
    import lhq_pkg::*;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIX
    } t_div_state;

    t_div_state  r_state;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [4:0]  r_cnt;

    logic [32:0] w_rem_sh;
    logic [33:0] w_diff;
    logic        w_ge;
    logic [31:0] w_num_mag;
    logic [31:0] w_den_mag;

    assign w_num_mag = i_num[32] ? 32'(-i_num) : i_num[31:0];
    assign w_den_mag = i_den[32] ? 32'(-i_den) : i_den[31:0];
    assign w_rem_sh  = {r_rem, r_quo[31]};
    assign w_diff    = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_ge      = !w_diff[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                DIV_IDLE: begin
                    if (i_start) begin
                        r_quo   <= w_num_mag;
                        r_den   <= w_den_mag;
                        r_rem   <= '0;
                        r_neg   <= i_num[32] ^ i_den[32];
                        r_cnt   <= '0;
                        r_state <= DIV_RUN;
                    end
                end
                DIV_RUN: begin
                    r_rem <= w_ge ? w_diff[31:0] : w_rem_sh[31:0];
                    r_quo <= {r_quo[30:0], w_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= DIV_FIX;
                    end
                end
                DIV_FIX: begin
                    // Round toward minus infinity when the signs differ.
                    if (r_neg) begin
                        o_quot <= -$signed(64'(r_quo)) - $signed(64'(r_rem != '0));
                    end else begin
                        o_quot <= $signed(64'(r_quo));
                    end
                    o_done  <= 1'b1;
                    r_state <= DIV_IDLE;
                end
                default: r_state <= DIV_IDLE;
            endcase
        end
    end

endmodule

### hdl/line_hull_max_query_top.sv
// ----------------------------------------------------------------------------
// line_hull_max_query_top
// Upper envelope of lines with floored breakpoints, insert/query/clear.
// ----------------------------------------------------------------------------
// Sequence: a clear, an unused command or a flagged beat goes from idle straight
// to the done state; a query walks k <= N-1 lines out and back, multiplies and adds;
// an insert seeks its place and divides for each breakpoint of unequal slopes.
// Throughput: one item at a time; the next beat is taken once the FSM is idle.
// Reset: synchronous, active low; it empties the store and the output stage.
// ----------------------------------------------------------------------------
module line_hull_max_query_top #(
    parameter int LINE_CAPACITY = lhq_pkg::LHQ_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] slope, [63:32] intercept, [95:64] query_point
    input  logic [95:0] i_s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [63:0] best_value, [70:64] line_count, [71] zero
    output logic [71:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser
);
    import lhq_pkg::*;

    localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

    // The store is split at a cursor into two stacks of cells. The right
    // stack holds the lines from the cursor on, its top is the line at the
    // cursor; the left stack holds the lines before it, nearest on top.
    // Moving the cursor moves one line between the tops. Between items the
    // cursor sits at zero, so every line is in the right stack.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SEEK,
        S_BRK_START,
        S_BRK_DIV,
        S_BRK_DONE,
        S_LOOP,
        S_LOOP_CMP,
        S_Q_SEEK,
        S_Q_MUL,
        S_Q_ADD,
        S_RET,
        S_DONE
    } t_state;

    // Which breakpoint update of the insert is running.
    typedef enum logic [1:0] {
        PH_A,   // new line against its successors
        PH_B1,  // predecessor against the new line
        PH_B2,  // predecessor after the new line was dropped
        PH_L    // backward cleanup sweep
    } t_phase;

    t_state             r_state;
    t_phase             r_phase;
    logic signed [31:0] r_slope;
    logic signed [31:0] r_icpt;
    logic signed [31:0] r_qx;
    logic signed [63:0] r_bp;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_best;
    t_status            r_status;
    logic               r_m_valid;
    logic signed [63:0] r_m_best;
    t_status            r_m_status;
    logic [6:0]         r_m_count;

    t_stack_ctl         w_lctl;
    t_stack_ctl         w_rctl;
    t_line              w_ltop;
    t_line              w_lsec;
    t_line              w_rtop;
    t_line              w_rsec;
    logic [CNT_W-1:0]   w_lcnt;
    logic [CNT_W-1:0]   w_rcnt;
    logic [CNT_W-1:0]   w_total;
    logic [CNT_W+6:0]   w_cnt_ext;

    t_line              w_bi;
    t_line              w_bj;
    logic               w_jexists;
    logic               w_cond;
    logic               w_div_start;
    logic signed [32:0] w_num;
    logic signed [32:0] w_den;
    logic               w_div_done;
    logic signed [63:0] w_quot;
    logic               w_accept;
    logic               w_out_free;
    logic signed [63:0] w_qx64;

    lhq_stack #(.DEPTH(LINE_CAPACITY)) u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lctl),
        .o_top    (w_ltop),
        .o_second (w_lsec),
        .o_count  (w_lcnt)
    );

    lhq_stack #(.DEPTH(LINE_CAPACITY)) u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_rctl),
        .o_top    (w_rtop),
        .o_second (w_rsec),
        .o_count  (w_rcnt)
    );

    lhq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_total    = w_lcnt + w_rcnt;
    assign w_cnt_ext  = (CNT_W + 7)'(w_total);
    assign w_accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_out_free = !r_m_valid || i_m_axis_tready;
    assign w_qx64     = 64'(r_qx);

    // Operands of the breakpoint update: line i gets its breakpoint against
    // line j. The new line's update reads the two right tops, the others
    // read the left top against the right top.
    assign w_bi      = (r_phase == PH_A) ? w_rtop : w_ltop;
    assign w_bj      = (r_phase == PH_A) ? w_rsec : w_rtop;
    assign w_jexists = (r_phase == PH_A) ? (w_rcnt >= CNT_W'(2)) : (w_rcnt != '0);
    assign w_cond    = w_jexists && (r_bp >= w_bj.bp);
    assign w_num     = 33'(w_bj.intercept) - 33'(w_bi.intercept);
    assign w_den     = 33'(w_bi.slope) - 33'(w_bj.slope);
    assign w_div_start = (r_state == S_BRK_START) && w_jexists &&
                         (w_bi.slope != w_bj.slope);

    // Stack controls follow the state directly.
    always_comb begin
        w_lctl = '{op: STK_HOLD, push: w_rtop, bp: r_bp};
        w_rctl = '{op: STK_HOLD, push: w_ltop, bp: r_bp};
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_s_axis_tuser == CMD_CLEAR)) begin
                    w_lctl.op = STK_CLEAR;
                    w_rctl.op = STK_CLEAR;
                end
            end
            S_INS_SEEK: begin
                if ((w_rcnt != '0) && (w_rtop.slope <= r_slope)) begin
                    w_lctl.op = STK_PUSH;
                    w_rctl.op = STK_POP;
                end else begin
                    w_rctl.op   = STK_PUSH;
                    w_rctl.push = '{slope: r_slope, intercept: r_icpt, bp: '0};
                end
            end
            S_BRK_DONE: begin
                case (r_phase)
                    PH_A:    w_rctl.op = w_cond ? STK_POP_SECOND : STK_SET_BP;
                    PH_B1: begin
                        w_lctl.op = STK_SET_BP;
                        if (w_cond) begin
                            w_rctl.op = STK_POP;
                        end
                    end
                    default: w_lctl.op = STK_SET_BP;
                endcase
            end
            S_LOOP: begin
                if (w_lcnt != CNT_W'(1)) begin
                    w_rctl.op = STK_PUSH;
                    w_lctl.op = STK_POP;
                end
            end
            S_LOOP_CMP: begin
                if (!(w_ltop.bp < w_rtop.bp)) begin
                    w_rctl.op = STK_POP;
                end
            end
            S_Q_SEEK: begin
                if ((w_rcnt > CNT_W'(1)) && (w_rtop.bp < w_qx64)) begin
                    w_lctl.op = STK_PUSH;
                    w_rctl.op = STK_POP;
                end
            end
            S_RET: begin
                if (w_lcnt != '0) begin
                    w_rctl.op = STK_PUSH;
                    w_lctl.op = STK_POP;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_A;
            r_m_valid <= 1'b0;
        end else begin
            // A taken result beat is cleared unless a new one replaces it.
            if (r_m_valid && i_m_axis_tready && !((r_state == S_DONE) && w_out_free)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_slope  <= i_s_axis_tdata[31:0];
                        r_icpt   <= i_s_axis_tdata[63:32];
                        r_qx     <= i_s_axis_tdata[95:64];
                        r_best   <= '0;
                        case (i_s_axis_tuser)
                            CMD_INSERT: begin
                                if (w_total == CNT_W'(LINE_CAPACITY)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_INS_SEEK;
                                end
                            end
                            CMD_QUERY: begin
                                if (w_total == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_Q_SEEK;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INS_SEEK: begin
                    if (!((w_rcnt != '0) && (w_rtop.slope <= r_slope))) begin
                        r_phase <= PH_A;
                        r_state <= S_BRK_START;
                    end
                end
                S_BRK_START: begin
                    if (!w_jexists) begin
                        r_bp    <= HULL_INF;
                        r_state <= S_BRK_DONE;
                    end else if (w_bi.slope == w_bj.slope) begin
                        r_bp    <= (w_bi.intercept > w_bj.intercept) ? HULL_INF : HULL_NEG_INF;
                        r_state <= S_BRK_DONE;
                    end else begin
                        r_state <= S_BRK_DIV;
                    end
                end
                S_BRK_DIV: begin
                    if (w_div_done) begin
                        r_bp    <= w_quot;
                        r_state <= S_BRK_DONE;
                    end
                end
                S_BRK_DONE: begin
                    case (r_phase)
                        PH_A: begin
                            if (w_cond) begin
                                r_state <= S_BRK_START;
                            end else if (w_lcnt == '0) begin
                                r_state <= S_RET;
                            end else begin
                                r_phase <= PH_B1;
                                r_state <= S_BRK_START;
                            end
                        end
                        PH_B1: begin
                            if (w_cond) begin
                                r_phase <= PH_B2;
                                r_state <= S_BRK_START;
                            end else begin
                                r_state <= S_LOOP;
                            end
                        end
                        default: r_state <= S_LOOP;
                    endcase
                end
                S_LOOP: begin
                    r_state <= (w_lcnt == CNT_W'(1)) ? S_RET : S_LOOP_CMP;
                end
                S_LOOP_CMP: begin
                    if (w_ltop.bp < w_rtop.bp) begin
                        r_state <= S_RET;
                    end else begin
                        r_phase <= PH_L;
                        r_state <= S_BRK_START;
                    end
                end
                S_Q_SEEK: begin
                    if (!((w_rcnt > CNT_W'(1)) && (w_rtop.bp < w_qx64))) begin
                        r_state <= S_Q_MUL;
                    end
                end
                S_Q_MUL: begin
                    r_prod  <= 64'(w_rtop.slope) * w_qx64;
                    r_state <= S_Q_ADD;
                end
                S_Q_ADD: begin
                    r_best  <= r_prod + 64'(w_rtop.intercept);
                    r_state <= S_RET;
                end
                S_RET: begin
                    if (w_lcnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_best   <= r_best;
                        r_m_status <= r_status;
                        r_m_count  <= w_cnt_ext[6:0];
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_m_count, r_m_best};
    assign o_m_axis_tuser  = r_m_status;

endmodule

### hdl/lhq_checker.sv
// ----------------------------------------------------------------------------
// lhq_checker
// Port-level checks of the line hull maximum query block, bound to its top.
// ----------------------------------------------------------------------------
module lhq_checker #(
    parameter int LINE_CAPACITY = lhq_pkg::LHQ_CAPACITY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [95:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import lhq_pkg::*;

    localparam logic [6:0] CAP7 = 7'(LINE_CAPACITY);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result beat changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_OK) |-> o_m_axis_tdata[63:0] == '0)
        else $error("flagged beat carries a nonzero value");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL) |-> o_m_axis_tdata[70:64] == CAP7)
        else $error("dropped insert without a full store");

endmodule

bind line_hull_max_query_top lhq_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_lhq_checker (.*);
